// ===== sv/red_pkg.sv =====
// Shared types and constants for the resonator envelope detector.
// Depends on nothing; every other file but red_req_if takes from it by scoped names.
package red_pkg;

   // Result field widths and limits.
   localparam int FILT_W = 32;
   localparam int AMP_W  = 31;
   localparam logic [AMP_W-1:0] AMP_MAX = {AMP_W{1'b1}};

   // Configuration port geometry and reset values.
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int GAIN_W      = 31;
   localparam logic [CSR_DATA_W-1:0] ENV_SCALE_RESET = 32'h0001_0000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INPUT_GAIN      = 2'd0,
      CSR_FIRST_FEEDBACK  = 2'd1,
      CSR_SECOND_FEEDBACK = 2'd2,
      CSR_ENVELOPE_SCALE  = 2'd3
   } csr_index_type;

   // Shared multiplier: signed 33 x 33 gives a 66-bit product.
   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;

   // Square root: 64-bit radicand, one result bit per step.
   localparam int RAD_W      = 64;
   localparam int ROOT_W     = 32;
   localparam int REM_W      = 34;
   localparam int ROOT_CNT_W = 5;
   localparam logic [ROOT_CNT_W-1:0] ROOT_LAST = ROOT_CNT_W'(ROOT_W - 1);

   // Scale on the output difference is Q16.16.
   localparam int SCALE_FRAC = 16;

   typedef enum logic [10:0] {
      ST_IDLE      = 11'b000_0000_0001,
      ST_MUL_GAIN  = 11'b000_0000_0010,
      ST_MUL_FB1   = 11'b000_0000_0100,
      ST_MUL_FB2   = 11'b000_0000_1000,
      ST_ROUND     = 11'b000_0001_0000,
      ST_ABS       = 11'b000_0010_0000,
      ST_MUL_DIFF  = 11'b000_0100_0000,
      ST_MUL_MEAN  = 11'b000_1000_0000,
      ST_MUL_ENV   = 11'b001_0000_0000,
      ST_ROOT_INIT = 11'b010_0000_0000,
      ST_ROOT      = 11'b100_0000_0000
   } state_type;

endpackage

// ===== sv/red_req_if.sv =====
// Input channel of the resonator envelope detector: one signed sample per transfer.
// Depends on nothing but its own parameter.
interface red_req_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// ===== sv/red_rsp_if.sv =====
// Result channel of the resonator envelope detector: filter output and envelope.
// Depends on red_pkg for the field widths.
interface red_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [red_pkg::FILT_W-1:0] filtered;
   logic        [red_pkg::AMP_W-1:0]  amplitude;

   modport source (output valid, output filtered, output amplitude, input ready);
   modport sink   (input valid, input filtered, input amplitude, output ready);
endinterface

// ===== sv/resonator_envelope_detector.sv =====
// Top level of the two-pole resonator with envelope output.
// Depends on red_pkg, red_req_if and red_rsp_if.
//
//   Channel   Direction  Contents                                   Handshake
//   req_chan  in         sample (SAMPLE_BITS, signed)               valid/ready
//   rsp_chan  out        filtered (32, signed), amplitude (31)      valid/ready
//   csr_*     in         write enable, 2-bit index, 32-bit data     write only
//
// Each sample passes through the multiply, rounding and setup steps around
// the shared multiplier, the bit-serial square root (one root bit per cycle,
// the last only once the result register is free; the last step also loads
// the result register) and the idle state, the only one in which the next
// transfer is accepted. Reset (synchronous, active high) clears the
// sequencer, the filter history and the result valid flag, and loads the
// coefficients with their reset values. A stalled result holds in its
// register; the block finishes the next sample and then waits in its last
// square root step until that register is free.
module resonator_envelope_detector #(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 30
) (
   input  logic                                clock,
   input  logic                                reset,
   red_req_if.sink                             req_chan,
   red_rsp_if.source                           rsp_chan,
   input  logic                                csr_write_en,
   input  logic [red_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [red_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int MW = red_pkg::MUL_W;
   localparam int PW = red_pkg::PROD_W;
   localparam int FW = red_pkg::FILT_W;

   // Half an output LSB, added before the arithmetic shift to round to nearest
   // with halves going toward plus infinity.
   localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) << (COEF_FRAC_BITS - 1);
   localparam logic signed [FW-1:0] FILT_MAX = {1'b0, {(FW-1){1'b1}}};
   localparam logic signed [FW-1:0] FILT_MIN = {1'b1, {(FW-1){1'b0}}};

   // Sequencer.
   red_pkg::state_type state_ff, state_in;
   logic [red_pkg::ROOT_CNT_W-1:0] cnt_ff, cnt_in;

   // Coefficient registers.
   logic        [red_pkg::GAIN_W-1:0]     gain_ff;
   logic signed [red_pkg::CSR_DATA_W-1:0] fb1_ff;
   logic signed [red_pkg::CSR_DATA_W-1:0] fb2_ff;
   logic        [red_pkg::CSR_DATA_W-1:0] scale_ff;

   // Filter history.
   logic signed [FW-1:0] last_ff, last_in;
   logic signed [FW-1:0] older_ff, older_in;

   // Datapath registers.
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic signed [PW-1:0]          prod_ff;
   logic signed [PW-1:0]          acc_ff, acc_in;
   logic        [FW:0]            mean_ff, mean_in;     // |last + older|, up to 2^32
   logic        [FW-1:0]          absd_ff, absd_in;     // |last - older|
   logic        [red_pkg::AMP_W-1:0] env_ff, env_in;   // scaled difference
   logic                          sat_ff, sat_in;
   logic        [red_pkg::RAD_W-1:0]  mean_sq_ff, mean_sq_in;
   logic        [red_pkg::RAD_W-1:0]  rad_ff, rad_in;
   logic        [red_pkg::REM_W-1:0]  rem_ff, rem_in;
   logic        [red_pkg::ROOT_W-1:0] root_ff, root_in;

   // Result register.
   logic                             rsp_valid_ff, rsp_valid_in;
   logic signed [FW-1:0]             rsp_filt_ff, rsp_filt_in;
   logic        [red_pkg::AMP_W-1:0] rsp_amp_ff, rsp_amp_in;

   // Shared multiplier operands.
   logic signed [MW-1:0] mul_a, mul_b;

   // Rounding and saturation of the filter sum.
   logic signed [PW-1:0] total, shifted;
   logic                 sat_hi, sat_lo;
   logic signed [FW-1:0] y_sat;

   // Envelope helpers.
   logic signed [FW:0]   pair_sum, pair_diff;
   logic [PW-1:0]        prod_u;
   logic [PW-red_pkg::SCALE_FRAC-1:0] env_wide;
   logic [red_pkg::RAD_W:0] rad_sum;

   // Square root step.
   logic [red_pkg::REM_W-1:0] rem_shift, trial;
   logic                      root_bit;

   logic req_xfer, rsp_free;

   assign req_chan.ready     = (state_ff == red_pkg::ST_IDLE);
   assign req_xfer           = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.filtered  = rsp_filt_ff;
   assign rsp_chan.amplitude = rsp_amp_ff;
   assign rsp_free           = !rsp_valid_ff || rsp_chan.ready;

   // The multiplier operands follow the step. All operands are widened to
   // 33 signed bits so that the unsigned gain, scale and magnitudes fit.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         red_pkg::ST_MUL_GAIN: begin
            mul_a = MW'({1'b0, gain_ff});
            mul_b = MW'(sample_ff);
         end
         red_pkg::ST_MUL_FB1: begin
            mul_a = MW'(fb1_ff);
            mul_b = MW'(last_ff);
         end
         red_pkg::ST_MUL_FB2: begin
            mul_a = MW'(fb2_ff);
            mul_b = MW'(older_ff);
         end
         red_pkg::ST_MUL_DIFF: begin
            mul_a = MW'({1'b0, absd_ff});
            mul_b = MW'({1'b0, scale_ff});
         end
         red_pkg::ST_MUL_MEAN: begin
            mul_a = MW'({1'b0, mean_ff[FW-1:0]});
            mul_b = MW'({1'b0, mean_ff[FW-1:0]});
         end
         red_pkg::ST_MUL_ENV: begin
            mul_a = MW'({1'b0, env_ff});
            mul_b = MW'({1'b0, env_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Rounding: the first two products less the third, plus half an LSB, shifted down
   // arithmetically, then clamped to the 32-bit range.
   always_comb begin
      total   = acc_ff - prod_ff + ROUND_HALF;
      shifted = total >>> COEF_FRAC_BITS;
      sat_hi  = !shifted[PW-1] && (|shifted[PW-2:FW-1]);
      sat_lo  = shifted[PW-1] && !(&shifted[PW-2:FW-1]);
      if (sat_hi) begin
         y_sat = FILT_MAX;
      end else if (sat_lo) begin
         y_sat = FILT_MIN;
      end else begin
         y_sat = shifted[FW-1:0];
      end
   end

   always_comb begin
      pair_sum  = (FW+1)'(last_ff) + (FW+1)'(older_ff);
      pair_diff = (FW+1)'(last_ff) - (FW+1)'(older_ff);
      prod_u    = prod_ff;
      env_wide  = prod_u[PW-1:red_pkg::SCALE_FRAC];
      rad_sum   = {1'b0, mean_sq_ff} + {prod_u[red_pkg::RAD_W-3:0], 2'b00};
   end

   // Restoring square root, two radicand bits in and one root bit out per step.
   always_comb begin
      rem_shift = {rem_ff[red_pkg::REM_W-3:0], rad_ff[red_pkg::RAD_W-1 -: 2]};
      trial     = {root_ff[red_pkg::REM_W-3:0], 2'b01};
      root_bit  = (rem_shift >= trial);
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      older_in     = older_ff;
      sample_in    = sample_ff;
      acc_in       = acc_ff;
      mean_in      = mean_ff;
      absd_in      = absd_ff;
      env_in       = env_ff;
      sat_in       = sat_ff;
      mean_sq_in   = mean_sq_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      rsp_filt_in  = rsp_filt_ff;
      rsp_amp_in   = rsp_amp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      case (state_ff)
         red_pkg::ST_IDLE: begin
            if (req_xfer) begin
               sample_in = req_chan.sample;
               state_in  = red_pkg::ST_MUL_GAIN;
            end
         end
         red_pkg::ST_MUL_GAIN: begin
            state_in = red_pkg::ST_MUL_FB1;
         end
         red_pkg::ST_MUL_FB1: begin
            acc_in   = prod_ff;
            state_in = red_pkg::ST_MUL_FB2;
         end
         red_pkg::ST_MUL_FB2: begin
            acc_in   = acc_ff + prod_ff;
            state_in = red_pkg::ST_ROUND;
         end
         red_pkg::ST_ROUND: begin
            older_in    = last_ff;
            last_in     = y_sat;
            state_in    = red_pkg::ST_ABS;
         end
         red_pkg::ST_ABS: begin
            mean_in  = pair_sum[FW] ? (FW+1)'(0) - pair_sum : pair_sum;
            absd_in  = pair_diff[FW] ? FW'((FW+1)'(0) - pair_diff) : pair_diff[FW-1:0];
            state_in = red_pkg::ST_MUL_DIFF;
         end
         red_pkg::ST_MUL_DIFF: begin
            state_in = red_pkg::ST_MUL_MEAN;
         end
         red_pkg::ST_MUL_MEAN: begin
            // The scaled difference saturates the envelope at 2^31 and above;
            // so does a mean magnitude of 2^32.
            env_in   = env_wide[red_pkg::AMP_W-1:0];
            sat_in   = (|env_wide[PW-red_pkg::SCALE_FRAC-1:red_pkg::AMP_W]) || mean_ff[FW];
            state_in = red_pkg::ST_MUL_ENV;
         end
         red_pkg::ST_MUL_ENV: begin
            mean_sq_in = prod_u[red_pkg::RAD_W-1:0];
            state_in   = red_pkg::ST_ROOT_INIT;
         end
         red_pkg::ST_ROOT_INIT: begin
            // Radicand is mean^2 + 4*env^2; a carry out of 64 bits saturates.
            rad_in   = rad_sum[red_pkg::RAD_W-1:0];
            sat_in   = sat_ff || rad_sum[red_pkg::RAD_W];
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = '0;
            state_in = red_pkg::ST_ROOT;
         end
         red_pkg::ST_ROOT: begin
            if (cnt_ff != red_pkg::ROOT_LAST || rsp_free) begin
               rad_in  = {rad_ff[red_pkg::RAD_W-3:0], 2'b00};
               rem_in  = root_bit ? rem_shift - trial : rem_shift;
               root_in = {root_ff[red_pkg::ROOT_W-2:0], root_bit};
               cnt_in  = cnt_ff + 1'b1;
            end
            if (cnt_ff == red_pkg::ROOT_LAST && rsp_free) begin
               // The envelope is half the root of the radicand. The filter
               // output still sits in the history register.
               rsp_filt_in  = last_ff;
               rsp_amp_in   = sat_ff ? red_pkg::AMP_MAX
                                     : root_in[red_pkg::ROOT_W-1:1];
               rsp_valid_in = 1'b1;
               state_in     = red_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = red_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= red_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         last_ff      <= '0;
         older_ff     <= '0;
         gain_ff      <= '0;
         fb1_ff       <= '0;
         fb2_ff       <= '0;
         scale_ff     <= red_pkg::ENV_SCALE_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
         older_ff     <= older_in;
         if (csr_write_en) begin
            case (red_pkg::csr_index_type'(csr_index))
               red_pkg::CSR_INPUT_GAIN:      gain_ff  <= csr_wdata[red_pkg::GAIN_W-1:0];
               red_pkg::CSR_FIRST_FEEDBACK:  fb1_ff   <= csr_wdata;
               red_pkg::CSR_SECOND_FEEDBACK: fb2_ff   <= csr_wdata;
               red_pkg::CSR_ENVELOPE_SCALE:  scale_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= mul_a * mul_b;
      sample_ff   <= sample_in;
      acc_ff      <= acc_in;
      mean_ff     <= mean_in;
      absd_ff     <= absd_in;
      env_ff      <= env_in;
      sat_ff      <= sat_in;
      mean_sq_ff  <= mean_sq_in;
      rad_ff      <= rad_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      rsp_filt_ff <= rsp_filt_in;
      rsp_amp_ff  <= rsp_amp_in;
   end

endmodule

// ===== sim/resonator_envelope_detector_test.sv =====
// Self-checking testbench for the resonator envelope detector: directed and random tests.
// Depends on red_pkg, red_req_if, red_rsp_if and the resonator_envelope_detector RTL.
`timescale 1ns / 100ps

module resonator_envelope_detector_test;

   localparam int SAMPLE_BITS    = 24;
   localparam int COEF_FRAC_BITS = 30;

   // Clock period is 8 ns. The limit is several times the slowest legal run:
   // about 1500 transfers, each paying for its own work, the longest source
   // gap and the longest result stall.
   localparam int          CYCLE_LIMIT   = 3_000_000;
   localparam int          SETTLE_CYCLES = 4;
   localparam int          TAIL_CYCLES   = 100;
   localparam int unsigned RANDOM_ITEMS  = 1450;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // Wide signed arithmetic for the filter sum: three products of up to 2^62
   // each can pass the range of 64 bits.
   localparam logic signed [71:0] HALF_LSB = 72'sd1 <<< (COEF_FRAC_BITS - 1);
   localparam logic signed [71:0] FILT_HI  = 72'sd2147483647;
   localparam logic signed [71:0] FILT_LO  = -72'sd2147483648;

   typedef struct packed {
      logic signed [red_pkg::FILT_W-1:0] filtered;
      logic        [red_pkg::AMP_W-1:0]  amplitude;
   } envelope_result_type;

   logic clock;
   logic reset;
   logic                            csr_write_en;
   logic [red_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [red_pkg::CSR_DATA_W-1:0]  csr_wdata;

   red_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_chan ();
   red_rsp_if                              rsp_chan ();

   resonator_envelope_detector #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Shadow copy of the coefficient registers and the filter history. The
   // history moves only when a sample transfer is accepted.
   logic        [red_pkg::GAIN_W-1:0]     input_gain_q;
   logic signed [red_pkg::CSR_DATA_W-1:0] first_fb_q;
   logic signed [red_pkg::CSR_DATA_W-1:0] second_fb_q;
   logic        [red_pkg::CSR_DATA_W-1:0] envelope_scale_q;
   logic signed [red_pkg::FILT_W-1:0]     last_q;
   logic signed [red_pkg::FILT_W-1:0]     older_q;

   // Results predicted for accepted samples, oldest first.
   envelope_result_type pending_results[$];

   int          error_count  = 0;
   int          cycle_count  = 0;
   int unsigned random_sent  = 0;
   bit          quiet        = 1'b0;   // when set, neither side inserts gaps

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // A hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL resonator_envelope_detector");
         $finish;
      end
   end

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int unsigned pick_gap(input int unsigned long_max);
      int unsigned sel;
      int unsigned gap;
      sel = $urandom_range(0, 99);
      if (quiet || sel < 50)
         gap = 0;
      else if (sel < 85)
         gap = $urandom_range(1, 3);
      else if (sel < 97)
         gap = $urandom_range(4, 20);
      else
         gap = $urandom_range(30, long_max);
      return gap;
   endfunction

   // Floor of the square root, one result bit at a time from the top.
   function automatic logic [31:0] int_sqrt(input logic [63:0] radicand);
      logic [31:0] root;
      logic [31:0] trial;
      logic [63:0] square;
      root = '0;
      for (int i = 31; i >= 0; i--) begin
         trial  = root | (32'd1 << i);
         square = {32'b0, trial} * {32'b0, trial};
         if (square <= radicand)
            root = trial;
      end
      return root;
   endfunction

   // Filter and envelope update for one accepted sample. The filter sum is
   // rounded half toward plus infinity, then saturated. The envelope is
   // floor(sqrt(a^2 + 4e^2)) / 2 with a = |last + older| and
   // e = floor(|last - older| * scale / 2^16), which keeps the mean exact.
   task automatic advance_resonator(input logic signed [SAMPLE_BITS-1:0] value,
                                    output envelope_result_type result);
      logic signed [71:0]                x_w, g_w, f1_w, f2_w, last_w, older_w, acc_w, y_w;
      logic signed [red_pkg::FILT_W-1:0] y;
      logic signed [33:0]                sum_w, diff_w;
      logic        [33:0]                mag_sum, mag_diff;
      logic        [65:0]                scaled, radicand;
      logic        [red_pkg::AMP_W-1:0]  amp;
      logic        [31:0]                root;
      x_w     = value;
      g_w     = $signed({41'b0, input_gain_q});
      f1_w    = first_fb_q;
      f2_w    = second_fb_q;
      last_w  = last_q;
      older_w = older_q;
      acc_w   = g_w * x_w + f1_w * last_w - f2_w * older_w + HALF_LSB;
      y_w     = acc_w >>> COEF_FRAC_BITS;
      if (y_w > FILT_HI)
         y = 32'sh7FFF_FFFF;
      else if (y_w < FILT_LO)
         y = 32'sh8000_0000;
      else
         y = y_w[red_pkg::FILT_W-1:0];

      older_q = last_q;
      last_q  = y;

      sum_w    = last_q + older_q;
      diff_w   = last_q - older_q;
      mag_sum  = (sum_w < 0) ? 34'(-sum_w) : 34'(sum_w);
      mag_diff = (diff_w < 0) ? 34'(-diff_w) : 34'(diff_w);
      scaled   = (mag_diff * envelope_scale_q) >> red_pkg::SCALE_FRAC;

      if (mag_sum >= 34'h1_0000_0000 || scaled >= (66'd1 << 31)) begin
         amp = red_pkg::AMP_MAX;
      end else begin
         radicand = mag_sum * mag_sum + ((scaled * scaled) << 2);
         if (radicand >= (66'd1 << 64)) begin
            amp = red_pkg::AMP_MAX;
         end else begin
            root = int_sqrt(radicand[63:0]) >> 1;
            amp  = (root > {1'b0, red_pkg::AMP_MAX}) ? red_pkg::AMP_MAX
                                                     : root[red_pkg::AMP_W-1:0];
         end
      end

      result.filtered  = y;
      result.amplitude = amp;
   endtask

   // Result side: compare each transfer with the oldest prediction, then
   // choose the next stall at random. The result side stays stalled until
   // reset is released.
   initial begin
      envelope_result_type want;
      int unsigned         hold;
      hold = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: result with none expected: filtered %0d amplitude %0d",
                        $time, rsp_chan.filtered, rsp_chan.amplitude);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_chan.filtered !== want.filtered) begin
                  $display("%0t: filtered mismatch: expected %0d, actual %0d",
                           $time, want.filtered, rsp_chan.filtered);
                  error_count++;
               end
               if (rsp_chan.amplitude !== want.amplitude) begin
                  $display("%0t: amplitude mismatch: expected %0d, actual %0d",
                           $time, want.amplitude, rsp_chan.amplitude);
                  error_count++;
               end
            end
         end
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (hold != 0) begin
            rsp_chan.ready <= 1'b0;
            hold--;
         end else begin
            rsp_chan.ready <= 1'b1;
            hold = pick_gap(200);
         end
      end
   end

   // One sample transfer. Valid is lowered only when a gap follows, so a
   // back-to-back transfer never sees valid dropped and raised in one step.
   // The caller lowers valid through wait_for_results when the stream pauses.
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
      int unsigned         gap;
      envelope_result_type predicted;
      gap = pick_gap(150);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.sample <= value;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      advance_resonator(value, predicted);
      pending_results.push_back(predicted);
   endtask

   // Stops the stream and waits until every predicted result has arrived.
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input red_pkg::csr_index_type index,
                            input logic [red_pkg::CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= data;
      @(posedge clock);
      case (index)
         red_pkg::CSR_INPUT_GAIN:      input_gain_q     = data[red_pkg::GAIN_W-1:0];
         red_pkg::CSR_FIRST_FEEDBACK:  first_fb_q       = data;
         red_pkg::CSR_SECOND_FEEDBACK: second_fb_q      = data;
         red_pkg::CSR_ENVELOPE_SCALE:  envelope_scale_q = data;
         default: ;
      endcase
   endtask

   // Coefficients change only with the block idle and nothing in flight.
   task automatic load_coefficients(input logic [red_pkg::CSR_DATA_W-1:0] gain,
                                    input logic [red_pkg::CSR_DATA_W-1:0] fb1,
                                    input logic [red_pkg::CSR_DATA_W-1:0] fb2,
                                    input logic [red_pkg::CSR_DATA_W-1:0] scale);
      wait_for_results();
      write_csr(red_pkg::CSR_INPUT_GAIN, gain);
      write_csr(red_pkg::CSR_FIRST_FEEDBACK, fb1);
      write_csr(red_pkg::CSR_SECOND_FEEDBACK, fb2);
      write_csr(red_pkg::CSR_ENVELOPE_SCALE, scale);
      csr_write_en <= 1'b0;
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      int unsigned                    sel;
      logic signed [SAMPLE_BITS-1:0]  value;
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
         value = SAMPLE_BITS'($urandom());
      end else if (sel < 85) begin
         value = SAMPLE_BITS'(int'($urandom_range(0, 510)) - 255);
      end else begin
         case ($urandom_range(0, 3))
            0:       value = SAMPLE_MAX;
            1:       value = SAMPLE_MIN;
            2:       value = '0;
            default: value = '1;
         endcase
      end
      return value;
   endfunction

   task automatic apply_reset();
      input_gain_q     = '0;
      first_fb_q       = '0;
      second_fb_q      = '0;
      envelope_scale_q = red_pkg::ENV_SCALE_RESET;
      last_q           = '0;
      older_q          = '0;
      reset <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   endtask

   // With the reset coefficients the gain is zero, so even the extreme
   // samples must give a zero output and a zero envelope.
   task automatic test_reset_defaults();
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
   endtask

   // Gain of one half makes every odd sample land on a half: halves go
   // toward plus infinity. A scale of 1.5 on odd differences exercises the
   // truncation of the scaled difference.
   task automatic test_filter_rounding();
      load_coefficients(32'h2000_0000, 32'h0, 32'h0, 32'h0001_8000);
      send_sample(SAMPLE_BITS'(1));
      send_sample(SAMPLE_BITS'(-1));
      send_sample(SAMPLE_BITS'(3));
      send_sample(SAMPLE_BITS'(-3));
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
   endtask

   // Extreme coefficients drive the filter into saturation at both rails and
   // the envelope into its own limit. The gain write sets bit 31, which the
   // 31-bit register drops.
   task automatic test_saturation();
      // Feedback of about +2 on both taps: the output runs up to the top rail,
      // and the full scale on a large difference saturates the envelope.
      load_coefficients(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      repeat (6) send_sample(SAMPLE_MAX);
      // Only the older tap, subtracted at +2: the output falls to the bottom
      // rail twice, so the sum of the two outputs reaches -2^32, then jumps
      // back to the top rail. A scale of zero removes the difference term.
      load_coefficients(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0);
      repeat (3) send_sample(SAMPLE_MAX);
      // Both taps at their most negative: the products nearly fill 64 bits.
      load_coefficients(32'h0, 32'h8000_0000, 32'h8000_0000, 32'h0001_0000);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
   endtask

   // One random phase: a fresh coefficient set, then a run of samples. Most
   // phases are stable resonators (poles inside the unit circle) so that the
   // output rings for a long time without saturating.
   task automatic run_random_phase();
      int unsigned                    kind;
      int unsigned                    count;
      int                             fb1_val;
      int                             fb2_val;
      real                            radius_sq;
      real                            fb1_lim;
      logic [red_pkg::CSR_DATA_W-1:0] gain;
      logic [red_pkg::CSR_DATA_W-1:0] scale;
      kind      = $urandom_range(0, 9);
      fb2_val   = int'($urandom_range(32'h2000_0000, 32'h3FF0_0000));
      radius_sq = fb2_val / 1073741824.0;
      fb1_lim   = 2.0 * $sqrt(radius_sq) * 0.999 * 1073741824.0;
      fb1_val   = $rtoi(($urandom_range(0, 2000) / 1000.0 - 1.0) * fb1_lim);
      gain      = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h1000_0000);
      scale     = $urandom_range(32'h0000_8000, 32'h0064_0000);
      if (kind < 6) begin
         load_coefficients(gain, fb1_val, fb2_val, scale);
      end else if (kind < 8) begin
         load_coefficients($urandom(), $urandom(), $urandom(), $urandom());
      end else if (kind == 8) begin
         load_coefficients($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h0,
                           $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000,
                           $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000,
                           $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
      end else begin
         // No input: the resonator rings down from whatever history it holds.
         load_coefficients(32'h0, fb1_val, fb2_val, scale);
      end
      quiet = ($urandom_range(0, 4) == 0);
      count = $urandom_range(40, 120);
      for (int i = 0; i < count; i++) begin
         // Now and then the stream stops until everything has come back.
         if ($urandom_range(0, 199) == 0)
            wait_for_results();
         send_sample(pick_sample());
         random_sent++;
      end
      quiet = 1'b0;
   endtask

   task automatic test_random_resonators();
      while (random_sent < RANDOM_ITEMS)
         run_random_phase();
   endtask

   // Every input is known from time zero; reset is raised by apply_reset.
   initial begin
      csr_write_en    <= 1'b0;
      csr_index       <= red_pkg::CSR_INPUT_GAIN;
      csr_wdata       <= '0;
      req_chan.valid  <= 1'b0;
      req_chan.sample <= '0;
      apply_reset();
      test_reset_defaults();
      test_filter_rounding();
      test_saturation();
      test_random_resonators();
      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("PASS resonator_envelope_detector");
      else
         $display("FAIL resonator_envelope_detector");
      $finish;
   end

endmodule
